FILE: rtl/cylindrical_point_projection_macros.svh
// Assertion macros shared by the projection pipeline.
`ifndef CYLINDRICAL_POINT_PROJECTION_MACROS_SVH
`define CYLINDRICAL_POINT_PROJECTION_MACROS_SVH
// Check that cond implies result on the same edge.
`define CPP_ASSERT_IMPL(label, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (result)) \
        else $error(msg);
// Check that cond implies result on the following edge.
`define CPP_ASSERT_NEXT(label, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);
`endif

FILE: rtl/cpp_pkg.sv
// Shared constants and tables of the cylindrical projection pipeline.
package cpp_pkg;
    localparam int FracBits    = 16;
    localparam int CordicSteps = 24;
    localparam int Guard       = 8;
    localparam int CordicW     = 44;
    localparam int AngW        = 36;
    localparam int NumW        = 63;
    localparam int RhoW        = 33;
    localparam logic [AngW-1:0] AngPi   = 36'd3373259426;
    localparam logic [31:0]     InvGain = 32'd652032874;

    localparam logic [1:0] RegFocalX  = 2'd0;
    localparam logic [1:0] RegFocalY  = 2'd1;
    localparam logic [1:0] RegCenterX = 2'd2;
    localparam logic [1:0] RegCenterY = 2'd3;

    function automatic logic [AngW-1:0] atan_step(input int i);
        logic [AngW-1:0] r;
        r = '0;
        case (i)
            0: r = 36'd843314856;
            1: r = 36'd497837829;
            2: r = 36'd263043836;
            3: r = 36'd133525158;
            4: r = 36'd67021686;
            5: r = 36'd33543515;
            6: r = 36'd16775850;
            7: r = 36'd8388437;
            8: r = 36'd4194282;
            9: r = 36'd2097149;
            default:
            begin
                if (i <= 30)
                    r = (AngW'(1) << (30 - i)) - AngW'(1);
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction
endpackage

FILE: rtl/cpp_divider.sv
// Pipelined restoring divider: one quotient bit per stage, rounded half up.
module cpp_divider
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             in_valid,
    input  logic [cpp_pkg::NumW-1:0]         numer,
    input  logic [cpp_pkg::RhoW-1:0]         denom,
    input  logic [63:0]                      side_in,
    output logic                             out_valid,
    output logic [cpp_pkg::NumW-1:0]         quot,
    output logic [63:0]                      side_out
);
    localparam int N  = cpp_pkg::NumW;
    localparam int DW = cpp_pkg::RhoW;

    logic               vld_s  [N+1];
    logic [N-1:0]       num_s  [N+1];
    logic [N-1:0]       q_s    [N+1];
    logic [DW:0]        rem_s  [N+1];
    logic [DW-1:0]      den_s  [N+1];
    logic [63:0]        side_s [N+1];

    assign num_s[0]  = numer;
    assign q_s[0]    = '0;
    assign rem_s[0]  = '0;
    assign den_s[0]  = denom;
    assign side_s[0] = side_in;
    assign vld_s[0]  = in_valid;

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [DW+1:0] shifted;
        logic [DW+1:0] diff;
        logic          vld_reg;
        logic [N-1:0]  num_reg;
        logic [N-1:0]  q_reg;
        logic [DW:0]   rem_reg;
        logic [DW-1:0] den_reg;
        logic [63:0]   side_reg;
        assign shifted = {rem_s[s], num_s[s][N-1-s]};
        assign diff    = shifted - {2'b00, den_s[s]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (advance)
                vld_reg <= vld_s[s];
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                num_reg  <= num_s[s];
                den_reg  <= den_s[s];
                side_reg <= side_s[s];
                if (!diff[DW+1])
                begin
                    rem_reg <= diff[DW:0];
                    q_reg   <= q_s[s] | (N'(1) << (N-1-s));
                end
                else
                begin
                    rem_reg <= shifted[DW:0];
                    q_reg   <= q_s[s];
                end
            end
        end
        assign vld_s[s+1]  = vld_reg;
        assign num_s[s+1]  = num_reg;
        assign q_s[s+1]    = q_reg;
        assign rem_s[s+1]  = rem_reg;
        assign den_s[s+1]  = den_reg;
        assign side_s[s+1] = side_reg;
    end

    // Round half up: remainder >= rho - floor(rho/2).
    logic [DW:0] half;
    assign half      = {1'b0, den_s[N]} - {2'b00, den_s[N][DW-1:1]};
    assign quot      = q_s[N] + ((rem_s[N] >= half) ? N'(1) : N'(0));
    assign out_valid = vld_s[N];
    assign side_out  = side_s[N];
endmodule

FILE: rtl/cylindrical_point_projection.sv
// Cylindrical camera projection: CORDIC radius/azimuth, then u and v with saturation.
// Pipeline: 91 register stages (front, 24 CORDIC, scale, rho, 63 divider, output).
// Throughput: one item per cycle while the output is not stalled; the 63-stage
// divider pipeline sets the depth.
// A stall on the output holds every stage; no item is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the
// intrinsics with focal lengths of 1.0 and a principal point of zero.
module cylindrical_point_projection
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // point_x, point_y, point_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // pixel_u, pixel_v
    output logic [1:0]   m_tuser,   // valid_res, saturated
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    `include "cylindrical_point_projection_macros.svh"

    localparam int CW = cpp_pkg::CordicW;
    localparam int AW = cpp_pkg::AngW;
    localparam int NS = cpp_pkg::CordicSteps;
    localparam int RhoW_l = cpp_pkg::RhoW;

    // Configuration registers.
    logic [30:0] focal_x_reg, focal_y_reg;
    logic [31:0] center_x_reg, center_y_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 31'(1) << cpp_pkg::FracBits;
            focal_y_reg  <= 31'(1) << cpp_pkg::FracBits;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cpp_pkg::RegFocalX:  focal_x_reg  <= cfg_data[30:0];
                cpp_pkg::RegFocalY:  focal_y_reg  <= cfg_data[30:0];
                cpp_pkg::RegCenterX: center_x_reg <= cfg_data;
                cpp_pkg::RegCenterY: center_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global stall: the whole pipe advances when the output is free.
    logic advance;
    logic out_vld_reg;
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = advance;

    // Front stage: fold left half plane, add guard bits.
    logic                 f_vld_reg;
    logic signed [CW-1:0] f_a_reg, f_b_reg;
    logic signed [AW-1:0] f_ang_reg;
    logic signed [31:0]   f_y_reg;
    logic                 f_zero_reg;
    logic signed [31:0] in_x, in_y, in_z;
    assign in_x = s_tdata[31:0];
    assign in_y = s_tdata[63:32];
    assign in_z = s_tdata[95:64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (advance)
            f_vld_reg <= s_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f_y_reg    <= in_y;
            f_zero_reg <= (in_x == 32'sd0) && (in_z == 32'sd0);
            if (in_z < 0)
            begin
                f_a_reg   <= -(CW'(in_z) <<< cpp_pkg::Guard);
                f_b_reg   <= -(CW'(in_x) <<< cpp_pkg::Guard);
                f_ang_reg <= (in_x >= 0) ? AW'(cpp_pkg::AngPi) : -AW'(cpp_pkg::AngPi);
            end
            else
            begin
                f_a_reg   <= CW'(in_z) <<< cpp_pkg::Guard;
                f_b_reg   <= CW'(in_x) <<< cpp_pkg::Guard;
                f_ang_reg <= '0;
            end
        end
    end

    // CORDIC vectoring stages, one rotation per stage.
    logic                 c_vld [NS+1];
    logic signed [CW-1:0] c_a   [NS+1];
    logic signed [CW-1:0] c_b   [NS+1];
    logic signed [AW-1:0] c_ang [NS+1];
    logic signed [31:0]   c_y   [NS+1];
    logic                 c_zero[NS+1];
    assign c_vld[0]  = f_vld_reg;
    assign c_a[0]    = f_a_reg;
    assign c_b[0]    = f_b_reg;
    assign c_ang[0]  = f_ang_reg;
    assign c_y[0]    = f_y_reg;
    assign c_zero[0] = f_zero_reg;
    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        logic signed [CW-1:0] da, db;
        logic signed [AW-1:0] step;
        assign da   = c_b[i] >>> i;
        assign db   = c_a[i] >>> i;
        assign step = cpp_pkg::atan_step(i);
        logic                 vld_reg;
        logic signed [CW-1:0] a_reg, b_reg;
        logic signed [AW-1:0] ang_reg;
        logic signed [31:0]   y_reg;
        logic                 zero_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (advance)
                vld_reg <= c_vld[i];
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                y_reg    <= c_y[i];
                zero_reg <= c_zero[i];
                if (c_b[i] >= 0)
                begin
                    a_reg   <= c_a[i] + da;
                    b_reg   <= c_b[i] - db;
                    ang_reg <= c_ang[i] + step;
                end
                else
                begin
                    a_reg   <= c_a[i] - da;
                    b_reg   <= c_b[i] + db;
                    ang_reg <= c_ang[i] - step;
                end
            end
        end
        assign c_vld[i+1]  = vld_reg;
        assign c_a[i+1]    = a_reg;
        assign c_b[i+1]    = b_reg;
        assign c_ang[i+1]  = ang_reg;
        assign c_y[i+1]    = y_reg;
        assign c_zero[i+1] = zero_reg;
    end

    // Scale stage: gain products; the radius product is split into two
    // 22 by 32 bit halves that the next stage adds back together.
    logic [CW-1:0] a_pos;
    logic [AW-1:0] ang_mag;
    logic [31:0]   y_mag;
    assign a_pos   = c_a[NS][CW-1] ? '0 : c_a[NS];
    assign ang_mag = c_ang[NS][AW-1] ? -c_ang[NS] : c_ang[NS];
    assign y_mag   = c_y[NS][31] ? -c_y[NS] : c_y[NS];

    logic          m_vld_reg, m_zero_reg, m_angneg_reg, m_yneg_reg;
    logic [53:0]   m_rho_hi_reg, m_rho_lo_reg;
    logic [66:0]   m_u_prod_reg;
    logic [62:0]   m_v_prod_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (advance)
            m_vld_reg <= c_vld[NS];
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_zero_reg     <= c_zero[NS];
            m_angneg_reg   <= c_ang[NS][AW-1];
            m_yneg_reg     <= c_y[NS][31];
            m_rho_hi_reg   <= 54'(a_pos[43:22]) * 54'(cpp_pkg::InvGain);
            m_rho_lo_reg   <= 54'(a_pos[21:0]) * 54'(cpp_pkg::InvGain);
            m_u_prod_reg   <= 67'(ang_mag) * 67'(focal_x_reg);
            m_v_prod_reg   <= 63'(y_mag) * 63'(focal_y_reg);
        end
    end

    // Rho and u stage.
    logic [75:0] rho_r;
    logic [RhoW_l-1:0] rho_val;
    assign rho_r   = (76'(m_rho_hi_reg) << 22) + 76'(m_rho_lo_reg) + (76'(1) << 37);
    assign rho_val = (rho_r[75:38] == '0) ? RhoW_l'(1) : RhoW_l'(rho_r[75:38]);
    logic [66:0] u_r;
    logic signed [38:0] u_sum;
    assign u_r   = m_u_prod_reg + (67'(1) << 29);
    assign u_sum = (m_angneg_reg ? -39'(u_r[66:30]) : 39'(u_r[66:30]))
                   + 39'(signed'(center_x_reg));

    logic          r_vld_reg;
    logic [62:0]   r_num_reg;
    logic [RhoW_l-1:0] r_rho_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_vld_reg <= 1'b0;
        else if (advance)
            r_vld_reg <= m_vld_reg;
    end
    logic [63:0] r_side_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r_num_reg  <= m_v_prod_reg;
            r_rho_reg  <= rho_val;
            // side: u clamped, u sat, yneg, zero
            r_side_reg[31:0] <= (u_sum > 39'sd2147483647) ? 32'h7FFFFFFF :
                                (u_sum < -39'sd2147483648) ? 32'h80000000 : u_sum[31:0];
            r_side_reg[32]   <= (u_sum > 39'sd2147483647) || (u_sum < -39'sd2147483648);
            r_side_reg[33]   <= m_yneg_reg;
            r_side_reg[34]   <= m_zero_reg;
            r_side_reg[63:35] <= '0;
        end
    end

    logic        d_vld;
    logic [62:0] d_quot;
    logic [63:0] d_side;
    cpp_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (r_vld_reg),
        .numer     (r_num_reg),
        .denom     (r_rho_reg),
        .side_in   (r_side_reg),
        .out_valid (d_vld),
        .quot      (d_quot),
        .side_out  (d_side)
    );

    // Output stage: sign, add center_y, clamp, zero-radius override.
    logic signed [64:0] v_sum;
    logic               v_sat;
    logic [31:0]        v_val;
    assign v_sum = (d_side[33] ? -65'(d_quot) : 65'(d_quot)) + 65'(signed'(center_y_reg));
    assign v_sat = (v_sum > 65'sd2147483647) || (v_sum < -65'sd2147483648);
    assign v_val = (v_sum > 65'sd2147483647) ? 32'h7FFFFFFF :
                   (v_sum < -65'sd2147483648) ? 32'h80000000 : v_sum[31:0];

    logic [63:0] out_data_reg;
    logic [1:0]  out_user_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= d_vld;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (d_side[34])
            begin
                out_data_reg <= '0;
                out_user_reg <= '0;
            end
            else
            begin
                out_data_reg <= {v_val, d_side[31:0]};
                out_user_reg <= {v_sat || d_side[32], 1'b1};
            end
        end
    end
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `CPP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "stalled output changed")
    `CPP_ASSERT_IMPL(a_ready, m_tvalid && !m_tready, !s_tready,
        "input taken during output stall")
    `CPP_ASSERT_IMPL(a_flags, m_tvalid && !m_tuser[0], m_tuser[1] == 1'b0 && m_tdata == '0,
        "undefined point carries data")
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the cylindrical point projection pipeline.
module tb;
    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        defined;
        logic        clamped;
    } pixel_t;

    localparam int DrainCycles = 150;
    localparam int WatchLimit  = 20000;
    localparam int HoldCycles  = 400;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;    // point_x, point_y, point_z
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;         // pixel_u, pixel_v
    logic [1:0]   m_tuser;         // valid_res, saturated
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = cpp_pkg::RegFocalX;
    logic [31:0]  cfg_data = '0;

    // Intrinsics as the predictor sees them
    longint unsigned focal_x_q, focal_y_q;
    longint          center_x_q, center_y_q;

    pixel_t pending_pixels[$];
    int     error_count = 0;
    int     idle_cycles = 0;
    bit     hold_request = 1'b0;
    bit     hold_active = 1'b0;
    bit     gaps_enabled = 1'b1;

    cylindrical_point_projection dut (.*);

    always #6 clk = ~clk;

    // Arctangent table, radians with 30 fraction bits
    function automatic longint arctan_q30(input int i);
        longint head[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                             33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10)
            return head[i];
        if (i <= 30)
            return (64'sd1 <<< (30 - i)) - 1;
        return 0;
    endfunction

    // Predict one projected pixel from a point
    function automatic pixel_t project_point(input logic [31:0] px, py, pz);
        pixel_t          r;
        longint          x, y, z, a, b, ang, da, db, sum;
        longint unsigned rho, mag;
        logic [127:0]    wide;
        x = longint'(signed'(px));
        y = longint'(signed'(py));
        z = longint'(signed'(pz));
        r = '0;
        if (x == 0 && z == 0)
            return r;
        // Turn left half-plane vectors by pi first
        if (z < 0)
        begin
            a = -z; b = -x;
            ang = (x >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        end
        else
        begin
            a = z; b = x; ang = 0;
        end
        a = a <<< cpp_pkg::Guard;
        b = b * (64'sd1 <<< cpp_pkg::Guard);
        for (int i = 0; i < cpp_pkg::CordicSteps; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0)
            begin
                a += da; b -= db; ang += arctan_q30(i);
            end
            else
            begin
                a -= da; b += db; ang -= arctan_q30(i);
            end
        end
        if (a < 0)
            a = 0;
        wide = 128'(a) * 128'(64'd652032874) + (128'd1 << (29 + cpp_pkg::Guard));
        rho = 64'(wide >> (30 + cpp_pkg::Guard));
        if (rho == 0)
            rho = 1;
        r.defined = 1'b1;
        // Horizontal: focal_x * phi, rounded half up on magnitude
        wide = 128'((ang < 0) ? -ang : ang) * 128'(focal_x_q) + (128'd1 << 29);
        mag = 64'(wide >> 30);
        sum = ((ang < 0) ? -longint'(mag) : longint'(mag)) + center_x_q;
        if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647; r.clamped = 1'b1;
        end
        else if (sum < -64'sd2147483648)
        begin
            sum = -64'sd2147483648; r.clamped = 1'b1;
        end
        r.u = sum[31:0];
        // Vertical: focal_y * y / rho, rounded half up on magnitude
        mag = longint'((y < 0) ? -y : y) * focal_y_q;
        mag = mag / rho + (((mag % rho) >= (rho - rho / 2)) ? 1 : 0);
        sum = ((y < 0) ? -longint'(mag) : longint'(mag)) + center_y_q;
        if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647; r.clamped = 1'b1;
        end
        else if (sum < -64'sd2147483648)
        begin
            sum = -64'sd2147483648; r.clamped = 1'b1;
        end
        r.v = sum[31:0];
        return r;
    endfunction

    // Offer one point, after a random gap when gaps are enabled; hold it until accepted
    task automatic send_point(input logic [31:0] px, py, pz);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_pixels.push_back(project_point(px, py, pz));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Write one register; only called with the pipeline empty
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cpp_pkg::RegFocalX:  focal_x_q  = longint'(val[30:0]);
            cpp_pkg::RegFocalY:  focal_y_q  = longint'(val[30:0]);
            cpp_pkg::RegCenterX: center_x_q = longint'(signed'(val));
            default:             center_y_q = longint'(signed'(val));
        endcase
    endtask

    task automatic set_intrinsics(input logic [31:0] fx, fy, cx, cy);
        write_reg(cpp_pkg::RegFocalX, fx);
        write_reg(cpp_pkg::RegFocalY, fy);
        write_reg(cpp_pkg::RegCenterX, cx);
        write_reg(cpp_pkg::RegCenterY, cy);
    endtask

    // Mix full-range, modest, zero and extreme coordinates
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return 32'($signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000);
            3:       return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
            4:       return '0;
            default: return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edges[6] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF,
                                  32'h80000000, 32'h00010000};
        send_point(32'h0, 32'h00050000, 32'h0);          // zero radius
        send_point(32'h0, 32'h80000000, 32'h0);          // zero radius, extreme y
        send_point(32'h1, 32'h00010000, 32'h0);          // tiny radius
        send_point(32'h0, 32'h7FFFFFFF, 32'hFFFFFFFF);   // tiny radius, clamps v
        send_point(32'h00010000, 32'h0, 32'hFFFF0000);   // behind, x positive
        send_point(32'hFFFF0000, 32'h0, 32'hFFFF0000);   // behind, x negative
        send_point(32'h0, 32'h0, 32'h80000000);          // straight back
        for (int i = 0; i < 6; i++)
            send_point(edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6]);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_point(32'h00030000, 32'h00020000, 32'h00040000);
        drain_pipeline();
    endtask

    task automatic test_register_sweep();
        // Extremes of each register, including the ignored top bit of the focals
        set_intrinsics(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        for (int i = 0; i < 40; i++)
            send_point(pick_coord(), pick_coord(), pick_coord());
        drain_pipeline();
        set_intrinsics(32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF);
        for (int i = 0; i < 40; i++)
            send_point(pick_coord(), pick_coord(), pick_coord());
        drain_pipeline();
        set_intrinsics(32'h01E00000, 32'h01E00000, 32'h02800000, 32'h01E00000);
        for (int i = 0; i < 40; i++)
            send_point(pick_coord(), pick_coord(), pick_coord());
        drain_pipeline();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 4; phase++)
        begin
            set_intrinsics($urandom, $urandom, $urandom, $urandom);
            gaps_enabled = (phase != 2);
            for (int i = 0; i < 250; i++)
                send_point(pick_coord(), pick_coord(), pick_coord());
            drain_pipeline();
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_backpressure();
        set_intrinsics(32'h00010000, 32'h00010000, 32'h0, 32'h0);
        gaps_enabled = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 200; i++)
            send_point(pick_coord(), pick_coord(), pick_coord());
        hold_request = 1'b0;
        gaps_enabled = 1'b1;
        drain_pipeline();
    endtask

    initial
    begin
        focal_x_q  = 64'd65536;
        focal_y_q  = 64'd65536;
        center_x_q = 0;
        center_y_q = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_register_sweep();
        test_random();
        test_backpressure();
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Long receiver hold-off, counted here so the sender keeps offering
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_active)
            begin
                hold_active = 1'b1;
                repeat (HoldCycles) @(posedge clk);
                hold_active = 1'b0;
                wait (!hold_request);
            end
        end
    end

    // Receiver: random stalls per item, with stall-free stretches
    initial
    begin
        int stall;
        int stretch;
        stall = 0;
        stretch = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (stretch > 0)
                begin
                    stretch--;
                    stall = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                    stretch = $urandom_range(20, 80);
                else
                    stall = $urandom_range(0, 10);
            end
            if (hold_active || !rst_n)
                m_tready <= 1'b0;
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compare each accepted pixel with the oldest prediction
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel with no prediction waiting: %h %h", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_tdata[31:0] !== want.u)
                begin
                    $error("pixel_u expected %h got %h", want.u, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[63:32] !== want.v)
                begin
                    $error("pixel_v expected %h got %h", want.v, m_tdata[63:32]);
                    error_count++;
                end
                if (m_tuser[0] !== want.defined)
                begin
                    $error("valid_res expected %b got %b", want.defined, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== want.clamped)
                begin
                    $error("saturated expected %b got %b", want.clamped, m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: stop when no item moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end
endmodule
